// ===== hw/rtl/msde_pkg.sv =====
// Package: shared types, codes and decode function for the subset executor.
package msde_pkg;

  localparam int unsigned MemWords = 256;
  localparam int unsigned MemAw = 8;
  localparam int unsigned QDepth = 2;

  typedef enum logic [1:0] {
    OP_EXEC  = 2'd0,
    OP_WMEM  = 2'd1,
    OP_RMEM  = 2'd2,
    OP_RREG  = 2'd3
  } op_e;

  typedef enum logic [4:0] {
    K_J = 5'd0, K_JR = 5'd1, K_BEQ = 5'd2, K_BLTZ = 5'd3, K_ADD = 5'd4,
    K_ADDI = 5'd5, K_SUB = 5'd6, K_SW = 5'd7, K_LW = 5'd8, K_SLL = 5'd9,
    K_SRL = 5'd10, K_MUL = 5'd11, K_AND = 5'd12, K_OR = 5'd13, K_MOVZ = 5'd14,
    K_NOP = 5'd15, K_BREAK = 5'd16, K_INVALID = 5'd17
  } kind_e;

  typedef enum logic [1:0] {
    ST_OK = 2'd0, ST_UNALIGNED = 2'd1, ST_RANGE = 2'd2
  } status_e;

  typedef struct packed {
    logic [1:0]         op;
    logic [31:0]        instruction_word;
    logic [31:0]        current_pc;
    logic [7:0]         word_index;
    logic [4:0]         register_index;
    logic signed [31:0] write_value;
  } in_item_t;

  typedef struct packed {
    logic [31:0]        next_pc;
    logic [1:0]         status;
    logic [4:0]         instr_kind;
    logic signed [31:0] read_value;
  } out_item_t;

  typedef struct packed {
    in_item_t item;
    kind_e    kind;
  } dec_item_t;

  function automatic kind_e classify(input logic [31:0] w);
    kind_e k;
    k = K_INVALID;
    if (!w[31]) begin
      k = K_INVALID;
    end else if (w[30:0] == 31'd0) begin
      k = K_NOP;
    end else begin
      case (w[30:26])
        5'h00: begin
          case (w[5:0])
            6'd0:  k = K_SLL;
            6'd2:  k = K_SRL;
            6'd8:  k = K_JR;
            6'd10: k = K_MOVZ;
            6'd13: k = K_BREAK;
            6'd32: k = K_ADD;
            6'd34: k = K_SUB;
            6'd36: k = K_AND;
            6'd37: k = K_OR;
            default: k = K_INVALID;
          endcase
        end
        5'h01: k = (w[20:16] == 5'd0) ? K_BLTZ : K_INVALID;
        5'h02: k = K_J;
        5'h03: k = K_LW;
        5'h04: k = K_BEQ;
        5'h08: k = K_ADDI;
        5'h0b: k = K_SW;
        5'h1c: k = (w[5:0] == 6'd2) ? K_MUL : K_INVALID;
        default: k = K_INVALID;
      endcase
    end
    return k;
  endfunction

endpackage

// ===== hw/rtl/msde_front.sv =====
// Front end: accepts items, classifies instructions, feeds a short queue.
module msde_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid,
  output logic               in_ready,
  input  msde_pkg::in_item_t in_item_i,
  output logic               q_valid_o,
  input  logic               q_ready_i,
  output msde_pkg::dec_item_t q_item_o
);
  import msde_pkg::*;

  dec_item_t buf_q [QDepth];
  logic      wptr_q, rptr_q;
  logic [1:0] cnt_q;
  logic      push, pop;

  assign in_ready  = (cnt_q != 2'(QDepth));
  assign push      = in_valid && in_ready;
  assign q_valid_o = (cnt_q != 2'd0);
  assign pop       = q_valid_o && q_ready_i;
  assign q_item_o  = buf_q[rptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      if (push) wptr_q <= ~wptr_q;
      if (pop)  rptr_q <= ~rptr_q;
      cnt_q <= cnt_q + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      buf_q[wptr_q].item <= in_item_i;
      buf_q[wptr_q].kind <= classify(in_item_i.instruction_word);
    end
  end

  cnt_range_a: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= 2'(QDepth)) else $error("queue count overflow");
  no_push_full_a: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == 2'(QDepth)) |-> !push) else $error("push into full queue");
  ptr_cnt_a: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == 2'd1) |-> (wptr_q != rptr_q)) else $error("pointer mismatch");
endmodule

// ===== hw/rtl/msde_back.sv =====
// Back end: executes one decoded item per cycle, unless the output is stalled, against registers and memory.
module msde_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we,
  input  logic [8:0]          cfg_wdata,
  input  logic                q_valid_i,
  output logic                q_ready_o,
  input  msde_pkg::dec_item_t q_item_i,
  output logic                out_valid,
  input  logic                out_ready,
  output msde_pkg::out_item_t out_item_o
);
  import msde_pkg::*;

  logic [31:0] rf_q [32];
  logic [31:0] mem_q [MemWords];
  logic [MemWords-1:0] mvld_q;
  logic [8:0]  wiu_q;
  logic        ov_q;
  out_item_t   res_q;
  logic        fire;
  logic [31:0] mrd_q;
  logic        rmem_q, lw_pend_q;
  logic [4:0]  lw_rt_q;

  in_item_t    it;
  kind_e       k;
  logic [4:0]  rs, rt, rd, sh;
  logic [31:0] a, b, simm, addr, pc, rv, wv;
  logic [29:0] waddr;
  logic [1:0]  st;
  logic        rf_we, m_we, lw_we;
  logic [4:0]  rf_wa;
  logic [MemAw-1:0] m_wa, m_ra;
  logic [8:0]  limit;
  logic [63:0] prod;

  assign q_ready_o  = !ov_q || out_ready;
  assign fire       = q_valid_i && q_ready_o;
  assign out_valid  = ov_q;

  always_comb begin
    out_item_o = res_q;
    if (rmem_q) out_item_o.read_value = mrd_q;
  end

  // a load's register write lands in the cycle after the load; forward it meanwhile
  always_comb begin
    it    = q_item_i.item;
    k     = q_item_i.kind;
    rs    = it.instruction_word[25:21];
    rt    = it.instruction_word[20:16];
    rd    = it.instruction_word[15:11];
    sh    = it.instruction_word[10:6];
    simm  = {{16{it.instruction_word[15]}}, it.instruction_word[15:0]};
    a     = (lw_pend_q && lw_rt_q == rs) ? mrd_q : rf_q[rs];
    b     = (lw_pend_q && lw_rt_q == rt) ? mrd_q : rf_q[rt];
    addr  = simm + a;
    waddr = addr[31:2];
    limit = (wiu_q < 9'(MemWords)) ? wiu_q : 9'(MemWords);
    prod  = a * b;
    pc    = it.current_pc;
    st    = ST_OK;
    rv    = 32'd0;
    rf_we = 1'b0;
    rf_wa = rd;
    wv    = 32'd0;
    m_we  = 1'b0;
    lw_we = 1'b0;
    m_wa  = it.word_index;
    m_ra  = it.word_index;
    case (op_e'(it.op))
      OP_WMEM: begin
        m_we = 1'b1;
        wv   = it.write_value;
      end
      OP_RMEM: ;
      OP_RREG: begin
        rv = (lw_pend_q && lw_rt_q == it.register_index) ? mrd_q :
             rf_q[it.register_index];
      end
      default: begin
        case (k)
          K_J:    pc = {it.instruction_word[29:0], 2'b00} & 32'h0FFF_FFFC;
          K_JR:   pc = a;
          K_BEQ:  if (a == b) pc = it.current_pc + {simm[29:0], 2'b00};
          K_BLTZ: if (a[31]) pc = it.current_pc + {simm[29:0], 2'b00};
          K_ADD:  begin rf_we = 1'b1; wv = a + b; end
          K_ADDI: begin rf_we = 1'b1; rf_wa = rt; wv = a + simm; end
          K_SUB:  begin rf_we = 1'b1; wv = a - b; end
          K_SLL:  begin rf_we = 1'b1; wv = b << sh; end
          K_SRL:  begin rf_we = 1'b1; wv = b >> sh; end
          K_MUL:  begin rf_we = 1'b1; wv = prod[31:0]; end
          K_AND:  begin rf_we = 1'b1; wv = a & b; end
          K_OR:   begin rf_we = 1'b1; wv = a | b; end
          K_MOVZ: begin rf_we = (b == 32'd0); wv = a; end
          K_SW, K_LW: begin
            if (addr[1:0] != 2'b00) begin
              st = ST_UNALIGNED;
            end else if (waddr >= 30'(limit)) begin
              st = ST_RANGE;
            end else begin
              m_wa = waddr[MemAw-1:0];
              m_ra = waddr[MemAw-1:0];
              if (k == K_SW) begin
                m_we = 1'b1;
                wv   = b;
              end else begin
                lw_we = (rt != 5'd0);
              end
            end
          end
          default: ;
        endcase
      end
    endcase
    if (rf_wa == 5'd0) rf_we = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q      <= 1'b0;
      wiu_q     <= 9'd256;
      mvld_q    <= '0;
      lw_pend_q <= 1'b0;
      lw_rt_q   <= 5'd0;
      for (int i = 0; i < 32; i++) rf_q[i] <= 32'd0;
    end else begin
      if (cfg_we) wiu_q <= cfg_wdata;
      if (fire) ov_q <= 1'b1;
      else if (out_ready) ov_q <= 1'b0;
      lw_pend_q <= fire && lw_we;
      if (fire && lw_we) lw_rt_q <= rt;
      if (lw_pend_q && !(fire && rf_we && rf_wa == lw_rt_q)) rf_q[lw_rt_q] <= mrd_q;
      if (fire && rf_we) rf_q[rf_wa] <= wv;
      if (fire && m_we) mvld_q[m_wa] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire && m_we) mem_q[m_wa] <= wv;
    if (fire) begin
      mrd_q            <= mvld_q[m_ra] ? mem_q[m_ra] : 32'd0;
      rmem_q           <= (it.op == OP_RMEM);
      res_q.next_pc    <= pc;
      res_q.status     <= st;
      res_q.instr_kind <= (it.op == OP_EXEC) ? k : K_NOP;
      res_q.read_value <= rv;
    end
  end

  r0_zero_a: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rf_q[0] == 32'd0) else $error("r0 written");
  hold_a: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ov_q && !out_ready) |=> (ov_q && $stable(res_q))) else $error("result lost");
  fire_a: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire |=> ov_q) else $error("result missing");
endmodule

// ===== hw/rtl/mips_subset_decode_execute_unit.sv =====
// Top level: MIPS subset decode and execute unit.
// Usage:
//   in channel (in_valid/in_ready, in_item_i) carries one op per item:
//   execute, write memory word, read memory word or read register.
//   out channel (out_valid/out_ready, out_item_o) returns one result per item.
//   cfg_we/cfg_wdata write words_in_use; write only while idle.
// Path from input accept to result valid: the queue, then the execute
// stage's output register.
// Throughput: one item per cycle while out_ready holds; the execute stage
// writes ALU results to the register file in the same cycle, reads memory
// into a register, and forwards a load's value to the next item, so
// dependent items follow back to back.
// Reset clears the register file, data memory (per-word valid bits) and the
// queue; words_in_use returns to 256.
// When the receiver stalls, the result register holds, the two-entry queue
// fills, then in_ready drops.
module mips_subset_decode_execute_unit (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we,
  input  logic [8:0]           cfg_wdata,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  msde_pkg::in_item_t   in_item_i,
  output logic                 out_valid,
  input  logic                 out_ready,
  output msde_pkg::out_item_t  out_item_o
);
  import msde_pkg::*;

  logic      q_valid, q_ready;
  dec_item_t q_item;

  msde_front u_front (
    .clk_i, .rst_ni, .in_valid, .in_ready, .in_item_i,
    .q_valid_o(q_valid), .q_ready_i(q_ready), .q_item_o(q_item)
  );

  msde_back u_back (
    .clk_i, .rst_ni, .cfg_we, .cfg_wdata,
    .q_valid_i(q_valid), .q_ready_o(q_ready), .q_item_i(q_item),
    .out_valid, .out_ready, .out_item_o
  );
endmodule

// ===== bench/tb_mips_subset_decode_execute_unit.sv =====
// Testbench for the MIPS subset decode and execute unit: predicted results, random traffic.
module tb_mips_subset_decode_execute_unit;
  timeunit 1ns;
  timeprecision 1ps;
  import msde_pkg::*;

  class exec_scoreboard;
    logic [31:0] regs [32];
    logic [31:0] mem [MemWords];
    logic [8:0]  words_in_use;
    out_item_t   pending [$];
    int          errors;

    function void clear();
      foreach (regs[i]) regs[i] = '0;
      foreach (mem[i]) mem[i] = '0;
      words_in_use = 9'd256;
      pending.delete();
      errors = 0;
    endfunction

    function void put_reg(logic [4:0] idx, logic [31:0] v);
      if (idx != 5'd0) regs[idx] = v;
    endfunction

    function void note_input(in_item_t it);
      out_item_t r;
      logic [31:0] w, a, b, simm, addr;
      logic [4:0] rs, rt, rd, sh;
      int unsigned lim;
      kind_e k;
      w = it.instruction_word;
      r.next_pc = it.current_pc;
      r.status = ST_OK;
      r.instr_kind = K_NOP;
      r.read_value = '0;
      case (op_e'(it.op))
        OP_WMEM: mem[it.word_index] = it.write_value;
        OP_RMEM: r.read_value = mem[it.word_index];
        OP_RREG: r.read_value = regs[it.register_index];
        default: begin
          rs = w[25:21]; rt = w[20:16]; rd = w[15:11]; sh = w[10:6];
          simm = {{16{w[15]}}, w[15:0]};
          a = regs[rs]; b = regs[rt];
          lim = (words_in_use < MemWords) ? words_in_use : MemWords;
          k = K_INVALID;
          if (w[31]) begin
            if (w[30:0] == 31'd0) k = K_NOP;
            else case (w[30:26])
              5'h00: case (w[5:0])
                6'd0: k = K_SLL; 6'd2: k = K_SRL; 6'd8: k = K_JR;
                6'd10: k = K_MOVZ; 6'd13: k = K_BREAK; 6'd32: k = K_ADD;
                6'd34: k = K_SUB; 6'd36: k = K_AND; 6'd37: k = K_OR;
                default: k = K_INVALID;
              endcase
              5'h01: if (rt == 5'd0) k = K_BLTZ;
              5'h02: k = K_J;
              5'h03: k = K_LW;
              5'h04: k = K_BEQ;
              5'h08: k = K_ADDI;
              5'h0b: k = K_SW;
              5'h1c: if (w[5:0] == 6'd2) k = K_MUL;
              default: k = K_INVALID;
            endcase
          end
          r.instr_kind = k;
          case (k)
            K_J:    r.next_pc = {4'd0, w[25:0], 2'b00};
            K_JR:   r.next_pc = a;
            K_BEQ:  if (a == b) r.next_pc = it.current_pc + (simm << 2);
            K_BLTZ: if (a[31]) r.next_pc = it.current_pc + (simm << 2);
            K_ADD:  put_reg(rd, a + b);
            K_ADDI: put_reg(rt, a + simm);
            K_SUB:  put_reg(rd, a - b);
            K_SW, K_LW: begin
              addr = simm + a;
              if (addr[1:0] != 2'b00) r.status = ST_UNALIGNED;
              else if ((addr >> 2) >= lim) r.status = ST_RANGE;
              else if (k == K_SW) mem[addr[9:2]] = b;
              else put_reg(rt, mem[addr[9:2]]);
            end
            K_SLL:  put_reg(rd, b << sh);
            K_SRL:  put_reg(rd, b >> sh);
            K_MUL:  put_reg(rd, a * b);
            K_AND:  put_reg(rd, a & b);
            K_OR:   put_reg(rd, a | b);
            K_MOVZ: if (b == 0) put_reg(rd, a);
            default: ;
          endcase
        end
      endcase
      pending.push_back(r);
    endfunction

    function void check_result(out_item_t got);
      out_item_t e;
      if (pending.size() == 0) begin
        $error("unexpected result %h", got);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (got.next_pc !== e.next_pc) begin
        $error("next_pc exp %h got %h", e.next_pc, got.next_pc); errors++;
      end
      if (got.status !== e.status) begin
        $error("status exp %0d got %0d", e.status, got.status); errors++;
      end
      if (got.instr_kind !== e.instr_kind) begin
        $error("instr_kind exp %0d got %0d", e.instr_kind, got.instr_kind); errors++;
      end
      if (got.read_value !== e.read_value) begin
        $error("read_value exp %h got %h", e.read_value, got.read_value); errors++;
      end
    endfunction
  endclass

  logic clk_i = 1'b0, rst_ni = 1'b0;
  logic cfg_we = 1'b0;
  logic [8:0] cfg_wdata = '0;
  logic in_valid = 1'b0, in_ready, out_valid, out_ready = 1'b0;
  in_item_t in_item_i = '0;
  out_item_t out_item_o;
  exec_scoreboard sb = new();
  bit hold_off = 1'b0;

  mips_subset_decode_execute_unit dut (.*);

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  initial begin
    #2000000;
    $display("simulation failed");
    $finish;
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid && out_ready) sb.check_result(out_item_o);
  end

  // receiver stall pattern, with an optional long hold-off
  initial begin
    int mode;
    forever begin
      mode = $urandom_range(0, 3);
      repeat ($urandom_range(5, 60)) begin
        @(posedge clk_i);
        if (hold_off) out_ready <= 1'b0;
        else if (mode == 0) out_ready <= 1'b1;
        else out_ready <= ($urandom_range(0, 3) >= mode - 1);
      end
    end
  end

  task automatic send_item(in_item_t it);
    in_valid <= 1'b1;
    in_item_i <= it;
    do @(posedge clk_i); while (!in_ready);
    sb.note_input(it);
  endtask

  task automatic pause_sender();
    in_valid <= 1'b0;
    repeat ($urandom_range(1, 6)) @(posedge clk_i);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic set_words(logic [8:0] v);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    sb.words_in_use = v;
  endtask

  function automatic in_item_t make_item(logic [1:0] op, logic [31:0] w);
    in_item_t it;
    it.op = op;
    it.instruction_word = w;
    it.current_pc = $urandom();
    it.word_index = 8'($urandom());
    it.register_index = 5'($urandom());
    it.write_value = $urandom();
    return it;
  endfunction

  function automatic logic [31:0] rtype(logic [5:0] fn);
    logic [31:0] w;
    w = $urandom();
    w[31] = 1'b1; w[30:26] = 5'h00; w[5:0] = fn;
    return w;
  endfunction

  function automatic logic [31:0] itype(logic [4:0] opc);
    logic [31:0] w;
    w = $urandom();
    w[31] = 1'b1; w[30:26] = opc;
    return w;
  endfunction

  // mostly decodable instructions, register numbers kept low for dependencies
  function automatic logic [31:0] rand_instr();
    logic [31:0] w;
    logic [5:0] fns [9] = '{6'd0, 6'd2, 6'd8, 6'd10, 6'd13, 6'd32, 6'd34, 6'd36, 6'd37};
    logic [4:0] opcs [8] = '{5'h01, 5'h02, 5'h03, 5'h04, 5'h08, 5'h0b, 5'h1c, 5'h03};
    case ($urandom_range(0, 9))
      0, 1, 2: w = rtype(fns[$urandom_range(0, 8)]);
      3, 4, 5, 6: w = itype(opcs[$urandom_range(0, 7)]);
      7: begin w = itype(5'h1c); w[5:0] = 6'd2; end
      8: w = itype(5'h0b);
      default: w = $urandom();
    endcase
    if ($urandom_range(0, 3) != 0) begin
      w[25:21] = 5'($urandom_range(0, 7));
      w[20:16] = 5'($urandom_range(0, 7));
      w[15:11] = 5'($urandom_range(0, 7));
    end
    if (w[30:26] == 5'h01 && $urandom_range(0, 3) != 0) w[20:16] = 5'd0;
    if ((w[30:26] == 5'h03 || w[30:26] == 5'h0b) && $urandom_range(0, 2) != 0) begin
      w[15:0] = 16'($urandom_range(0, 300) << 2);
      if ($urandom_range(0, 3) == 0) w[25:21] = 5'd0;
    end
    return w;
  endfunction

  task automatic random_phase(int n);
    in_item_t it;
    int burst;
    while (n > 0) begin
      burst = $urandom_range(1, 20);
      while (burst > 0 && n > 0) begin
        it = make_item(2'($urandom_range(0, 3)), rand_instr());
        if ($urandom_range(0, 1)) it.op = OP_EXEC;
        send_item(it);
        burst--; n--;
      end
      if ($urandom_range(0, 2) == 0) pause_sender();
    end
  endtask

  initial begin
    in_item_t it;
    logic [31:0] w;
    sb.clear();
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: fills, a subset of the kinds, special cases
    it = make_item(OP_WMEM, '0); it.word_index = 8'd255; it.write_value = 32'h8000_0000;
    send_item(it);
    it = make_item(OP_RMEM, '0); it.word_index = 8'd255; send_item(it);
    w = itype(5'h08); w[25:21] = 5'd0; w[20:16] = 5'd1; w[15:0] = 16'hFFFF;
    send_item(make_item(OP_EXEC, w));
    w = itype(5'h08); w[25:21] = 5'd0; w[20:16] = 5'd2; w[15:0] = 16'h7FFF;
    send_item(make_item(OP_EXEC, w));
    w = itype(5'h08); w[25:21] = 5'd0; w[20:16] = 5'd0; send_item(make_item(OP_EXEC, w));
    w = 32'h8000_0000; send_item(make_item(OP_EXEC, w));
    send_item(make_item(OP_EXEC, 32'h0000_0000));
    send_item(make_item(OP_EXEC, 32'h7FFF_FFFF));
    send_item(make_item(OP_EXEC, 32'hFFFF_FFFF));
    w = rtype(6'd13); send_item(make_item(OP_EXEC, w));
    w = rtype(6'd2); w[20:16] = 5'd1; w[10:6] = 5'd31; w[15:11] = 5'd3;
    send_item(make_item(OP_EXEC, w));
    w = itype(5'h01); w[25:21] = 5'd1; w[20:16] = 5'd0; w[15:0] = 16'h8000;
    send_item(make_item(OP_EXEC, w));
    w = itype(5'h01); w[20:16] = 5'd4; send_item(make_item(OP_EXEC, w));
    w = itype(5'h02); w[25:0] = 26'h3FFFFFF; send_item(make_item(OP_EXEC, w));
    w = itype(5'h04); w[25:21] = 5'd0; w[20:16] = 5'd0; send_item(make_item(OP_EXEC, w));
    w = itype(5'h1c); w[5:0] = 6'd3; send_item(make_item(OP_EXEC, w));
    w = itype(5'h0b); w[25:21] = 5'd0; w[15:0] = 16'd2; send_item(make_item(OP_EXEC, w));
    w = itype(5'h03); w[25:21] = 5'd0; w[20:16] = 5'd0; w[15:0] = 16'd1020;
    send_item(make_item(OP_EXEC, w));
    w = itype(5'h03); w[25:21] = 5'd1; w[15:0] = 16'h0003; send_item(make_item(OP_EXEC, w));
    w = rtype(6'd10); w[20:16] = 5'd0; w[15:11] = 5'd5; send_item(make_item(OP_EXEC, w));
    it = make_item(OP_RREG, '0); it.register_index = 5'd31; send_item(it);
    it = make_item(OP_RREG, '0); it.register_index = 5'd0; send_item(it);
    drain();

    set_words(9'd1);
    w = itype(5'h0b); w[25:21] = 5'd0; w[15:0] = 16'd4; send_item(make_item(OP_EXEC, w));
    w = itype(5'h03); w[25:21] = 5'd0; w[15:0] = 16'd0; send_item(make_item(OP_EXEC, w));
    random_phase(200);
    drain();
    set_words(9'd511);
    random_phase(400);

    // long receiver hold-off while items keep coming
    hold_off = 1'b1;
    fork
      begin repeat (200) @(posedge clk_i); hold_off = 1'b0; end
      random_phase(30);
    join
    drain();
    set_words(9'd0);
    random_phase(150);
    drain();
    set_words(9'($urandom_range(2, 255)));
    random_phase(300);
    drain();
    set_words(9'd256);
    random_phase(300);
    drain();
    repeat (10) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending.size() == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end
endmodule
